>>> design/smt_pkg.sv
// Shared types and codes for the subscription match table.
package smt_pkg;

  // Widths fixed by the request and result fields.
  localparam int ADDR_W  = 64;
  localparam int KEY_W   = 64;
  localparam int IFACE_W = 32;
  localparam int TOKEN_W = 64;
  localparam int TLEN_W  = 4;
  localparam int MASK_W  = 32;
  localparam int COUNT_W = 5;
  localparam int BYTE_W  = 8;

  typedef enum logic [1:0] {
    FUNC_APPEND = 2'd0,
    FUNC_FIND   = 2'd1,
    FUNC_DELETE = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_BAD_INDEX = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic write;    // load the request as a new entry
    logic shift;    // take the entry of the next cell up
    logic capture;  // load the scan slot from this cell's compare
    logic advance;  // take the scan slot of the next cell up
  } cell_ctrl_t;

endpackage

>>> design/smt_cell.sv
// One table cell: an entry, its compare against the request, and a scan slot.
module smt_cell #(
  parameter int KEY_BITS = 64,
  parameter int TOK_BITS = 64
) (
  input  logic                          clk,
  input  smt_pkg::cell_ctrl_t           ctrl,
  input  logic                          live,
  input  logic [smt_pkg::ADDR_W-1:0]    req_addr_hi,
  input  logic [smt_pkg::ADDR_W-1:0]    req_addr_lo,
  input  logic [KEY_BITS-1:0]           req_dev,
  input  logic [smt_pkg::IFACE_W-1:0]   req_iface,
  input  logic [TOK_BITS-1:0]           req_tok,
  input  logic [smt_pkg::TLEN_W-1:0]    req_tlen,
  input  logic [smt_pkg::MASK_W-1:0]    req_mask,
  input  logic [smt_pkg::ADDR_W-1:0]    nb_addr_hi,
  input  logic [smt_pkg::ADDR_W-1:0]    nb_addr_lo,
  input  logic [KEY_BITS-1:0]           nb_dev,
  input  logic [smt_pkg::IFACE_W-1:0]   nb_iface,
  input  logic [TOK_BITS-1:0]           nb_tok,
  input  logic [smt_pkg::TLEN_W-1:0]    nb_tlen,
  input  logic [smt_pkg::MASK_W-1:0]    nb_mask,
  input  logic                          nb_scan_hit,
  input  logic [smt_pkg::MASK_W-1:0]    nb_scan_mask,
  output logic [smt_pkg::ADDR_W-1:0]    addr_hi,
  output logic [smt_pkg::ADDR_W-1:0]    addr_lo,
  output logic [KEY_BITS-1:0]           dev,
  output logic [smt_pkg::IFACE_W-1:0]   iface,
  output logic [TOK_BITS-1:0]           tok,
  output logic [smt_pkg::TLEN_W-1:0]    tlen,
  output logic [smt_pkg::MASK_W-1:0]    mask,
  output logic                          scan_hit,
  output logic [smt_pkg::MASK_W-1:0]    scan_mask
);

  logic hit;

  assign hit = live && (addr_hi == req_addr_hi) && (addr_lo == req_addr_lo) &&
               (dev == req_dev) && (iface == req_iface) &&
               (tlen == req_tlen) && (tok == req_tok);

  // Entry: append writes the request, delete pulls the upper neighbor down.
  always_ff @(posedge clk) begin
    if (ctrl.write) begin
      addr_hi <= req_addr_hi;
      addr_lo <= req_addr_lo;
      dev     <= req_dev;
      iface   <= req_iface;
      tok     <= req_tok;
      tlen    <= req_tlen;
      mask    <= req_mask;
    end else if (ctrl.shift) begin
      addr_hi <= nb_addr_hi;
      addr_lo <= nb_addr_lo;
      dev     <= nb_dev;
      iface   <= nb_iface;
      tok     <= nb_tok;
      tlen    <= nb_tlen;
      mask    <= nb_mask;
    end
  end

  // Scan slot: capture the compare, then march toward cell 0.
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      scan_hit  <= hit;
      scan_mask <= mask;
    end else if (ctrl.advance) begin
      scan_hit  <= nb_scan_hit;
      scan_mask <= nb_scan_mask;
    end
  end

endmodule

>>> design/subscription_match_table_core.sv
// Top level of the subscription match table: request capture, sequencer and cell row.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------------------
//  in      | to core   | in_valid / in_stall  | func, peer_addr_hi/lo, device_key,
//          |           |                      | iface_id, token_bytes, token_count,
//          |           |                      | attr_mask, target_index
//  out     | from core | out_valid / out_stall| status, found, match_index, match_mask,
//          |           |                      | entry_count
//
// Append, delete and unused codes pass from accept through the execute and finish steps to the result register.
// Find passes through execute, then scans up to the first hit or, on a miss, the entry
// count, then finish: the hit flags step down the cell row one
// cell per cycle and the sequencer inspects cell 0.
// Delete moves every entry above the target down by one place at once, in the execute step.
// Reset clears the sequencer, the entry count and the output valid; entries are
// never read above the entry count, so the cells need no clearing.
// The core takes one item at a time; it accepts a new item while a finished
// result still waits under out_stall, and holds the next result until the slot frees.
module subscription_match_table_core #(
  parameter int ENTRIES         = 20,
  parameter int DEVICE_KEY_BITS = 64,
  parameter int TOKEN_MAX_BYTES = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    func,
  input  logic [smt_pkg::ADDR_W-1:0]    peer_addr_hi,
  input  logic [smt_pkg::ADDR_W-1:0]    peer_addr_lo,
  input  logic [smt_pkg::KEY_W-1:0]     device_key,
  input  logic [smt_pkg::IFACE_W-1:0]   iface_id,
  input  logic [smt_pkg::TOKEN_W-1:0]   token_bytes,
  input  logic [smt_pkg::TLEN_W-1:0]    token_count,
  input  logic [smt_pkg::MASK_W-1:0]    attr_mask,
  input  logic [smt_pkg::COUNT_W-1:0]   target_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    status,
  output logic                          found,
  output logic [smt_pkg::COUNT_W-1:0]   match_index,
  output logic [smt_pkg::MASK_W-1:0]    match_mask,
  output logic [smt_pkg::COUNT_W-1:0]   entry_count
);

  localparam int TOK_BITS = TOKEN_MAX_BYTES * smt_pkg::BYTE_W;
  localparam logic [smt_pkg::COUNT_W-1:0] ENTRIES_C = smt_pkg::COUNT_W'(ENTRIES);
  localparam logic [smt_pkg::TLEN_W-1:0]  TLEN_MAX  = smt_pkg::TLEN_W'(TOKEN_MAX_BYTES);

  // Sequencer state
  smt_pkg::state_t                state, state_next;
  logic [smt_pkg::COUNT_W-1:0]    count, count_next;
  logic [smt_pkg::COUNT_W-1:0]    scan_cnt, scan_cnt_next;

  // Captured request
  logic [1:0]                     req_func;
  logic [smt_pkg::ADDR_W-1:0]     req_addr_hi;
  logic [smt_pkg::ADDR_W-1:0]     req_addr_lo;
  logic [DEVICE_KEY_BITS-1:0]     req_dev;
  logic [smt_pkg::IFACE_W-1:0]    req_iface;
  logic [TOK_BITS-1:0]            req_tok;
  logic [smt_pkg::TLEN_W-1:0]     req_tlen;
  logic [smt_pkg::MASK_W-1:0]     req_mask;
  logic [smt_pkg::COUNT_W-1:0]    req_tgt;

  // Pending result
  logic [1:0]                     res_status, res_status_next;
  logic                           res_found, res_found_next;
  logic [smt_pkg::COUNT_W-1:0]    res_idx, res_idx_next;
  logic [smt_pkg::MASK_W-1:0]     res_mask, res_mask_next;

  logic                           accept;
  logic                           out_free;
  logic                           load_out;
  logic                           do_write, do_shift, do_capture, do_advance;
  logic [smt_pkg::TLEN_W-1:0]     tlen_sat;
  logic [TOK_BITS-1:0]            tok_masked;

  // Cell row; slot ENTRIES feeds the top cell.
  smt_pkg::cell_ctrl_t            cell_ctrl [ENTRIES];
  logic                           cell_live [ENTRIES];
  logic [smt_pkg::ADDR_W-1:0]     c_addr_hi [ENTRIES+1];
  logic [smt_pkg::ADDR_W-1:0]     c_addr_lo [ENTRIES+1];
  logic [DEVICE_KEY_BITS-1:0]     c_dev     [ENTRIES+1];
  logic [smt_pkg::IFACE_W-1:0]    c_iface   [ENTRIES+1];
  logic [TOK_BITS-1:0]            c_tok     [ENTRIES+1];
  logic [smt_pkg::TLEN_W-1:0]     c_tlen    [ENTRIES+1];
  logic [smt_pkg::MASK_W-1:0]     c_mask    [ENTRIES+1];
  logic                           c_hit     [ENTRIES+1];
  logic [smt_pkg::MASK_W-1:0]     c_smask   [ENTRIES+1];

  assign in_stall = (state != smt_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Saturate the token length and zero the bytes past it.
  assign tlen_sat = (token_count > TLEN_MAX) ? TLEN_MAX : token_count;

  always_comb begin
    tok_masked = '0;
    for (int b = 0; b < TOKEN_MAX_BYTES; b++) begin
      if (smt_pkg::TLEN_W'(b) < tlen_sat) begin
        tok_masked[b*smt_pkg::BYTE_W +: smt_pkg::BYTE_W] =
          token_bytes[b*smt_pkg::BYTE_W +: smt_pkg::BYTE_W];
      end
    end
  end

  // Hold the request for the whole operation.
  always_ff @(posedge clk) begin
    if (accept) begin
      req_func    <= func;
      req_addr_hi <= peer_addr_hi;
      req_addr_lo <= peer_addr_lo;
      req_dev     <= device_key[DEVICE_KEY_BITS-1:0];
      req_iface   <= iface_id;
      req_tok     <= tok_masked;
      req_tlen    <= tlen_sat;
      req_mask    <= attr_mask;
      req_tgt     <= target_index;
    end
  end

  // State and count registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smt_pkg::ST_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    scan_cnt   <= scan_cnt_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
    res_idx    <= res_idx_next;
    res_mask   <= res_mask_next;
  end

  // Next state and cell control
  always_comb begin
    state_next      = state;
    count_next      = count;
    scan_cnt_next   = scan_cnt;
    res_status_next = res_status;
    res_found_next  = res_found;
    res_idx_next    = res_idx;
    res_mask_next   = res_mask;
    do_write        = 1'b0;
    do_shift        = 1'b0;
    do_capture      = 1'b0;
    do_advance      = 1'b0;
    load_out        = 1'b0;
    unique case (state)
      smt_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = smt_pkg::ST_EXEC;
        end
      end
      smt_pkg::ST_EXEC: begin
        res_status_next = smt_pkg::STATUS_OK;
        res_found_next  = 1'b0;
        res_idx_next    = '0;
        res_mask_next   = '0;
        state_next      = smt_pkg::ST_FINISH;
        unique case (req_func)
          smt_pkg::FUNC_APPEND: begin
            if (count >= ENTRIES_C) begin
              res_status_next = smt_pkg::STATUS_FULL;
            end else begin
              do_write     = 1'b1;
              res_idx_next = count;
              count_next   = count + 1'b1;
            end
          end
          smt_pkg::FUNC_FIND: begin
            do_capture    = 1'b1;
            scan_cnt_next = '0;
            state_next    = smt_pkg::ST_SCAN;
          end
          smt_pkg::FUNC_DELETE: begin
            if (req_tgt >= count) begin
              res_status_next = smt_pkg::STATUS_BAD_INDEX;
            end else begin
              do_shift   = 1'b1;
              count_next = count - 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      smt_pkg::ST_SCAN: begin
        // Cell 0 holds the flag of entry scan_cnt; stop at the first hit or the end.
        priority if (scan_cnt == count) begin
          state_next = smt_pkg::ST_FINISH;
        end else if (c_hit[0]) begin
          res_found_next = 1'b1;
          res_idx_next   = scan_cnt;
          res_mask_next  = c_smask[0];
          state_next     = smt_pkg::ST_FINISH;
        end else begin
          do_advance    = 1'b1;
          scan_cnt_next = scan_cnt + 1'b1;
        end
      end
      smt_pkg::ST_FINISH: begin
        if (out_free) begin
          load_out   = 1'b1;
          state_next = smt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = smt_pkg::ST_IDLE;
      end
    endcase
  end

  // Output register: fill when the slot is free, drop valid when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      status      <= res_status;
      found       <= res_found;
      match_index <= res_idx;
      match_mask  <= res_mask;
      entry_count <= count;
    end
  end

  // Above the top cell: the shift brings in don't-care data, the scan brings no hit.
  assign c_addr_hi[ENTRIES] = req_addr_hi;
  assign c_addr_lo[ENTRIES] = req_addr_lo;
  assign c_dev[ENTRIES]     = req_dev;
  assign c_iface[ENTRIES]   = req_iface;
  assign c_tok[ENTRIES]     = req_tok;
  assign c_tlen[ENTRIES]    = req_tlen;
  assign c_mask[ENTRIES]    = req_mask;
  assign c_hit[ENTRIES]     = 1'b0;
  assign c_smask[ENTRIES]   = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    assign cell_live[i]         = (smt_pkg::COUNT_W'(i) < count);
    assign cell_ctrl[i].write   = do_write && (count == smt_pkg::COUNT_W'(i));
    assign cell_ctrl[i].shift   = do_shift && (smt_pkg::COUNT_W'(i) >= req_tgt);
    assign cell_ctrl[i].capture = do_capture;
    assign cell_ctrl[i].advance = do_advance;

    smt_cell #(
      .KEY_BITS (DEVICE_KEY_BITS),
      .TOK_BITS (TOK_BITS)
    ) u_cell (
      .clk          (clk),
      .ctrl         (cell_ctrl[i]),
      .live         (cell_live[i]),
      .req_addr_hi  (req_addr_hi),
      .req_addr_lo  (req_addr_lo),
      .req_dev      (req_dev),
      .req_iface    (req_iface),
      .req_tok      (req_tok),
      .req_tlen     (req_tlen),
      .req_mask     (req_mask),
      .nb_addr_hi   (c_addr_hi[i+1]),
      .nb_addr_lo   (c_addr_lo[i+1]),
      .nb_dev       (c_dev[i+1]),
      .nb_iface     (c_iface[i+1]),
      .nb_tok       (c_tok[i+1]),
      .nb_tlen      (c_tlen[i+1]),
      .nb_mask      (c_mask[i+1]),
      .nb_scan_hit  (c_hit[i+1]),
      .nb_scan_mask (c_smask[i+1]),
      .addr_hi      (c_addr_hi[i]),
      .addr_lo      (c_addr_lo[i]),
      .dev          (c_dev[i]),
      .iface        (c_iface[i]),
      .tok          (c_tok[i]),
      .tlen         (c_tlen[i]),
      .mask         (c_mask[i]),
      .scan_hit     (c_hit[i]),
      .scan_mask    (c_smask[i])
    );
  end

  // The table never holds more entries than it has cells.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ENTRIES_C)
    else $error("entry count above table size");

  // The count moves only in the execute step.
  a_count_exec: assert property (@(posedge clk) disable iff (rst)
    !$stable(count) |-> $past(state == smt_pkg::ST_EXEC))
    else $error("entry count changed outside execute");

  // The scan never runs past the live entries.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == smt_pkg::ST_SCAN) |-> (scan_cnt <= count))
    else $error("scan index past entry count");

  // A new result appears only out of the finish step.
  a_out_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == smt_pkg::ST_FINISH))
    else $error("result raised outside finish");

endmodule

>>> tb/tb_subscription_match_table_core.sv
// Self-checking testbench for the subscription match table core.
`timescale 1ns / 1ps

module tb_subscription_match_table_core;

  localparam int ENTRIES         = 20;
  localparam int DEVICE_KEY_BITS = 64;
  localparam int TOKEN_MAX_BYTES = 8;

  // Code that the core treats as a no-op.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  localparam logic [smt_pkg::KEY_W-1:0] KEY_KEEP =
    {smt_pkg::KEY_W{1'b1}} >> (smt_pkg::KEY_W - DEVICE_KEY_BITS);

  localparam int RANDOM_ITEMS = 1300;
  localparam int POOL_DEPTH   = 24;
  localparam int HOLD_CYCLES  = 300;

  // One request item as presented on the input channel.
  typedef struct {
    logic [1:0]                  func;
    logic [smt_pkg::ADDR_W-1:0]  addr_hi;
    logic [smt_pkg::ADDR_W-1:0]  addr_lo;
    logic [smt_pkg::KEY_W-1:0]   key;
    logic [smt_pkg::IFACE_W-1:0] iface;
    logic [smt_pkg::TOKEN_W-1:0] token;
    logic [smt_pkg::TLEN_W-1:0]  tcount;
    logic [smt_pkg::MASK_W-1:0]  mask;
    logic [smt_pkg::COUNT_W-1:0] target;
  } table_req_t;

  // One reply item from the output channel.
  typedef struct {
    logic [1:0]                  status;
    logic                        found;
    logic [smt_pkg::COUNT_W-1:0] index;
    logic [smt_pkg::MASK_W-1:0]  mask;
    logic [smt_pkg::COUNT_W-1:0] count;
  } table_rsp_t;

  // One stored subscription, normalized as the core keeps it.
  typedef struct {
    logic [smt_pkg::ADDR_W-1:0]  addr_hi;
    logic [smt_pkg::ADDR_W-1:0]  addr_lo;
    logic [smt_pkg::KEY_W-1:0]   key;
    logic [smt_pkg::IFACE_W-1:0] iface;
    logic [smt_pkg::TOKEN_W-1:0] token;
    logic [smt_pkg::TLEN_W-1:0]  tlen;
    logic [smt_pkg::MASK_W-1:0]  mask;
  } sub_entry_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                        in_valid     = 1'b0;
  logic                        in_stall;
  logic [1:0]                  func         = '0;
  logic [smt_pkg::ADDR_W-1:0]  peer_addr_hi = '0;
  logic [smt_pkg::ADDR_W-1:0]  peer_addr_lo = '0;
  logic [smt_pkg::KEY_W-1:0]   device_key   = '0;
  logic [smt_pkg::IFACE_W-1:0] iface_id     = '0;
  logic [smt_pkg::TOKEN_W-1:0] token_bytes  = '0;
  logic [smt_pkg::TLEN_W-1:0]  token_count  = '0;
  logic [smt_pkg::MASK_W-1:0]  attr_mask    = '0;
  logic [smt_pkg::COUNT_W-1:0] target_index = '0;
  logic                        out_valid;
  logic                        out_stall    = 1'b0;
  logic [1:0]                  status;
  logic                        found;
  logic [smt_pkg::COUNT_W-1:0] match_index;
  logic [smt_pkg::MASK_W-1:0]  match_mask;
  logic [smt_pkg::COUNT_W-1:0] entry_count;

  subscription_match_table_core #(
    .ENTRIES         (ENTRIES),
    .DEVICE_KEY_BITS (DEVICE_KEY_BITS),
    .TOKEN_MAX_BYTES (TOKEN_MAX_BYTES)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .peer_addr_hi (peer_addr_hi),
    .peer_addr_lo (peer_addr_lo),
    .device_key   (device_key),
    .iface_id     (iface_id),
    .token_bytes  (token_bytes),
    .token_count  (token_count),
    .attr_mask    (attr_mask),
    .target_index (target_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .found        (found),
    .match_index  (match_index),
    .match_mask   (match_mask),
    .entry_count  (entry_count)
  );

  // Requests waiting to be driven, and replies the table must still produce.
  table_req_t request_queue[$];
  table_rsp_t expected_replies[$];

  // Shadow of the subscription table, advanced once per accepted item.
  sub_entry_t sub_table[ENTRIES];
  int         sub_count = 0;

  // Generator-side view: entry count and recently appended requests,
  // so finds can aim at entries that are likely still present.
  int         gen_count = 0;
  table_req_t append_pool[$];

  int accepted_items = 0;
  int mismatch_count = 0;

  // Sender burst state.
  table_req_t drive_item;
  int         burst_left = 0;
  int         gap_left   = 0;

  // Receiver stall pattern and long hold-off.
  logic [8:0] stall_phase = '0;
  int         hold_left   = 0;
  int         hold_count  = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  // Compute the reply of one request and advance the shadow table.
  function automatic table_rsp_t predict_table_op(table_req_t r);
    table_rsp_t                   rsp;
    int unsigned                  tlen;
    logic [smt_pkg::TOKEN_W-1:0]  keep;
    logic [smt_pkg::TOKEN_W-1:0]  tok;
    logic [smt_pkg::KEY_W-1:0]    key;
    bit                           hit;
    rsp  = '{status: smt_pkg::STATUS_OK, found: 1'b0, index: '0, mask: '0, count: '0};
    tlen = (r.tcount > TOKEN_MAX_BYTES) ? TOKEN_MAX_BYTES : r.tcount;
    // Bytes past the token length are dropped before storing or comparing.
    if (tlen == 0)
      keep = '0;
    else if (tlen >= 8)
      keep = '1;
    else
      keep = (64'd1 << (smt_pkg::BYTE_W * tlen)) - 64'd1;
    tok = r.token & keep;
    key = r.key & KEY_KEEP;
    hit = 1'b0;
    case (r.func)
      smt_pkg::FUNC_APPEND: begin
        if (sub_count >= ENTRIES) begin
          rsp.status = smt_pkg::STATUS_FULL;
        end else begin
          sub_table[sub_count] = '{addr_hi: r.addr_hi, addr_lo: r.addr_lo, key: key,
                                   iface: r.iface, token: tok,
                                   tlen: tlen[smt_pkg::TLEN_W-1:0], mask: r.mask};
          rsp.index = sub_count[smt_pkg::COUNT_W-1:0];
          sub_count++;
        end
      end
      smt_pkg::FUNC_FIND: begin
        // Lowest index wins.
        for (int i = 0; i < sub_count; i++) begin
          if (!hit && sub_table[i].addr_hi == r.addr_hi && sub_table[i].addr_lo == r.addr_lo
              && sub_table[i].key == key && sub_table[i].iface == r.iface
              && sub_table[i].tlen == tlen && sub_table[i].token == tok) begin
            hit       = 1'b1;
            rsp.found = 1'b1;
            rsp.index = i[smt_pkg::COUNT_W-1:0];
            rsp.mask  = sub_table[i].mask;
          end
        end
      end
      smt_pkg::FUNC_DELETE: begin
        if (r.target >= sub_count) begin
          rsp.status = smt_pkg::STATUS_BAD_INDEX;
        end else begin
          for (int i = r.target; i + 1 < sub_count; i++)
            sub_table[i] = sub_table[i + 1];
          sub_count--;
        end
      end
      default: ;
    endcase
    rsp.count = sub_count[smt_pkg::COUNT_W-1:0];
    return rsp;
  endfunction

  function automatic table_req_t make_req(logic [1:0] f, logic [63:0] hi, logic [63:0] lo,
                                          logic [63:0] key, logic [31:0] ifc,
                                          logic [63:0] tok, logic [3:0] cnt,
                                          logic [31:0] msk, logic [4:0] tgt);
    table_req_t r;
    r = '{func: f, addr_hi: hi, addr_lo: lo, key: key, iface: ifc, token: tok,
          tcount: cnt, mask: msk, target: tgt};
    return r;
  endfunction

  // Random 64-bit value, leaning on the all-zero and all-one extremes.
  function automatic logic [63:0] pick64();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0)
      return '0;
    if (roll == 1)
      return '1;
    return {$urandom(), $urandom()};
  endfunction

  function automatic table_req_t random_req();
    table_req_t r;
    r.func    = smt_pkg::FUNC_APPEND;
    r.addr_hi = pick64();
    r.addr_lo = pick64();
    r.key     = pick64();
    r.iface   = 32'(pick64());
    r.token   = pick64();
    r.tcount  = ($urandom_range(0, 4) < 2) ? 4'd8 : 4'($urandom_range(0, 15));
    r.mask    = 32'(pick64());
    r.target  = 5'($urandom_range(0, 31));
    return r;
  endfunction

  // Change one compared field of a request so it just misses its entry.
  function automatic table_req_t near_miss(table_req_t r);
    int unsigned tlen;
    tlen = (r.tcount > TOKEN_MAX_BYTES) ? TOKEN_MAX_BYTES : r.tcount;
    case ($urandom_range(0, 5))
      0: r.addr_hi[$urandom_range(0, smt_pkg::ADDR_W - 1)] ^= 1'b1;
      1: r.addr_lo[$urandom_range(0, smt_pkg::ADDR_W - 1)] ^= 1'b1;
      2: r.key[$urandom_range(0, DEVICE_KEY_BITS - 1)] ^= 1'b1;
      3: r.iface[$urandom_range(0, smt_pkg::IFACE_W - 1)] ^= 1'b1;
      4: begin
        if (tlen > 0)
          r.token[$urandom_range(0, smt_pkg::BYTE_W * tlen - 1)] ^= 1'b1;
        else
          r.tcount = 4'd1;
      end
      default: r.tcount = (tlen < TOKEN_MAX_BYTES) ? 4'(tlen + 1) : 4'(TOKEN_MAX_BYTES - 1);
    endcase
    return r;
  endfunction

  // Queue one request and track the entry count the table will have.
  function automatic void push_request(table_req_t r);
    request_queue.push_back(r);
    if (r.func == smt_pkg::FUNC_APPEND && gen_count < ENTRIES) begin
      gen_count++;
      append_pool.push_back(r);
      if (append_pool.size() > POOL_DEPTH)
        void'(append_pool.pop_front());
    end else if (r.func == smt_pkg::FUNC_DELETE && r.target < gen_count) begin
      gen_count--;
    end
  endfunction

  // Driver: present queued items in bursts, hold each item while stalled.
  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_replies.push_back(predict_table_op(drive_item));
        accepted_items <= accepted_items + 1;
      end
      // Only move on once the current item is gone or nothing is offered.
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_queue.size() > 0) begin
          drive_item   = request_queue.pop_front();
          func         <= drive_item.func;
          peer_addr_hi <= drive_item.addr_hi;
          peer_addr_lo <= drive_item.addr_lo;
          device_key   <= drive_item.key;
          iface_id     <= drive_item.iface;
          token_bytes  <= drive_item.token;
          token_count  <= drive_item.tcount;
          attr_mask    <= drive_item.mask;
          target_index <= drive_item.target;
          in_valid     <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            // Start a new burst; some bursts follow with no gap at all.
            burst_left = $urandom_range(0, 15);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off: stop taking replies for a stretch so the core backs up
  // and stalls its input while the driver keeps offering items.
  always @(posedge clk) begin
    if (rst) begin
      hold_left  <= 0;
      hold_count <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_count < 2 && accepted_items >= 400 + hold_count * 600) begin
      hold_left  <= HOLD_CYCLES;
      hold_count <= hold_count + 1;
    end
  end

  // Receiver stall pattern: cycle through free, light, heavy and alternating stall.
  always @(posedge clk) begin
    logic pattern;
    if (rst) begin
      out_stall   <= 1'b0;
      stall_phase <= '0;
    end else begin
      case (stall_phase[8:7])
        2'd0:    pattern = 1'b0;
        2'd1:    pattern = ($urandom_range(0, 3) == 0);
        2'd2:    pattern = ($urandom_range(0, 3) != 0);
        default: pattern = stall_phase[0];
      endcase
      stall_phase <= stall_phase + 1'b1;
      out_stall   <= (hold_left != 0) || pattern;
    end
  end

  // Monitor: check each accepted reply against the oldest expectation.
  always @(posedge clk) begin
    table_rsp_t exp_rsp;
    if (!rst && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected reply: status %0d found %0d index %0d mask %h count %0d",
                   status, found, match_index, match_mask, entry_count);
        mismatch_count++;
      end else begin
        exp_rsp = expected_replies.pop_front();
        if ({status, found, match_index, match_mask, entry_count} !==
            {exp_rsp.status, exp_rsp.found, exp_rsp.index, exp_rsp.mask, exp_rsp.count}) begin
          if (mismatch_count < 10)
            $display("reply mismatch: exp status %0d found %0d index %0d mask %h count %0d",
                     exp_rsp.status, exp_rsp.found, exp_rsp.index, exp_rsp.mask,
                     exp_rsp.count, " / got status %0d found %0d index %0d mask %h count %0d",
                     status, found, match_index, match_mask, entry_count);
          mismatch_count++;
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    table_req_t  ent_a, ent_b, ent_c, ent_d, q;
    int unsigned roll, pick, tlen;
    int          phase, app_lim, find_lim, del_lim;
    logic [63:0] keep;

    // Directed part: extremes, every code, the empty table and out-of-range deletes.
    ent_a = make_req(smt_pkg::FUNC_APPEND, '1, '1, '1, '1, '1, 4'd8, '1, '1);
    ent_b = make_req(smt_pkg::FUNC_APPEND, '0, '0, '0, '0, '0, 4'd0, '0, '0);
    ent_c = make_req(smt_pkg::FUNC_APPEND, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                     64'h00c0_ffee_0000_0001, 32'h0000_0010, 64'h8877_6655_4433_2211,
                     4'd15, 32'h5a5a_a5a5, 5'd0);
    ent_d = make_req(smt_pkg::FUNC_APPEND, 64'h2001_0db8_0000_0000, 64'h0000_0000_0000_0001,
                     64'h1234, 32'd7, 64'hffff_ffff_ffab_cdef, 4'd3, 32'h8000_0001, 5'd0);

    // Find and delete on an empty table, then an unused code.
    q = ent_a; q.func = smt_pkg::FUNC_FIND; push_request(q);
    q = ent_b; q.func = smt_pkg::FUNC_DELETE; q.target = 5'd0; push_request(q);
    q = ent_b; q.func = FUNC_UNUSED; push_request(q);
    push_request(ent_a);
    push_request(ent_b);
    push_request(ent_c);
    push_request(ent_d);
    q = ent_a; q.func = smt_pkg::FUNC_FIND; push_request(q);
    q = ent_b; q.func = smt_pkg::FUNC_FIND; push_request(q);
    // Oversized token length saturates on find as on append.
    q = ent_c; q.func = smt_pkg::FUNC_FIND; q.tcount = 4'd9; push_request(q);
    // Bytes past the length do not take part in the compare.
    q = ent_d; q.func = smt_pkg::FUNC_FIND; q.token = 64'h0123_4567_89ab_cdef;
    push_request(q);
    q = ent_d; q.func = smt_pkg::FUNC_FIND; q.tcount = 4'd4; push_request(q);
    q = ent_a; q.func = smt_pkg::FUNC_FIND; q.iface[0] = 1'b0; push_request(q);
    // Duplicate entry: find must return the lower index.
    push_request(ent_a);
    q = ent_a; q.func = smt_pkg::FUNC_FIND; push_request(q);
    q = ent_a; q.func = smt_pkg::FUNC_DELETE; q.target = 5'd31; push_request(q);
    q = ent_a; q.func = smt_pkg::FUNC_DELETE; q.target = 5'd5; push_request(q);
    q = ent_a; q.func = smt_pkg::FUNC_DELETE; q.target = 5'd0; push_request(q);
    q = ent_a; q.func = smt_pkg::FUNC_FIND; push_request(q);
    q = ent_a; q.func = smt_pkg::FUNC_DELETE; q.target = 5'd3; push_request(q);
    q = ent_a; q.func = smt_pkg::FUNC_FIND; push_request(q);
    q = ent_a; q.func = FUNC_UNUSED; push_request(q);
    q = ent_b; q.func = smt_pkg::FUNC_DELETE; q.target = 5'd1; push_request(q);
    q = ent_d; q.func = smt_pkg::FUNC_FIND; push_request(q);

    // Random part: phases lean toward append (fill to full), mixed, and
    // delete (drain to empty), with finds aimed mostly at live entries.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      phase = (n / 100) % 3;
      case (phase)
        0:       begin app_lim = 60; find_lim = 85; del_lim = 97; end
        1:       begin app_lim = 35; find_lim = 75; del_lim = 95; end
        default: begin app_lim = 15; find_lim = 50; del_lim = 95; end
      endcase
      roll = $urandom_range(0, 99);
      pick = $urandom_range(0, 9);
      if (roll < app_lim) begin
        if (append_pool.size() > 0 && pick < 3)
          q = append_pool[$urandom_range(0, append_pool.size() - 1)];
        else if (append_pool.size() > 0 && pick < 5)
          q = near_miss(append_pool[$urandom_range(0, append_pool.size() - 1)]);
        else
          q = random_req();
        q.func   = smt_pkg::FUNC_APPEND;
        q.mask   = 32'(pick64());
        q.target = 5'($urandom_range(0, 31));
      end else if (roll < find_lim) begin
        if (append_pool.size() > 0 && pick < 5) begin
          q    = append_pool[$urandom_range(0, append_pool.size() - 1)];
          tlen = (q.tcount > TOKEN_MAX_BYTES) ? TOKEN_MAX_BYTES : q.tcount;
          keep = (tlen == 0) ? 64'd0 :
                 (tlen >= 8) ? '1 : (64'd1 << (smt_pkg::BYTE_W * tlen)) - 64'd1;
          // Scramble the ignored bytes and vary a saturated length.
          q.token = (q.token & keep) | ({$urandom(), $urandom()} & ~keep);
          if (tlen == TOKEN_MAX_BYTES && $urandom_range(0, 1) == 1)
            q.tcount = 4'($urandom_range(TOKEN_MAX_BYTES, 15));
        end else if (append_pool.size() > 0 && pick < 7) begin
          q = near_miss(append_pool[$urandom_range(0, append_pool.size() - 1)]);
        end else begin
          q = random_req();
        end
        q.func = smt_pkg::FUNC_FIND;
        q.mask = 32'(pick64());
      end else if (roll < del_lim) begin
        q      = random_req();
        q.func = smt_pkg::FUNC_DELETE;
        if (gen_count > 0 && $urandom_range(0, 4) != 0)
          q.target = 5'($urandom_range(0, gen_count - 1));
        else
          q.target = 5'($urandom_range(0, 31));
      end else begin
        q      = random_req();
        q.func = FUNC_UNUSED;
      end
      push_request(q);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Drain: all items accepted, all replies in, then let the core settle.
    while (request_queue.size() != 0 || in_valid)
      @(posedge clk);
    while (expected_replies.size() != 0)
      @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);

    if (mismatch_count == 0 && expected_replies.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #8_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> filelist.f
design/smt_pkg.sv
design/smt_cell.sv
design/subscription_match_table_core.sv
tb/tb_subscription_match_table_core.sv
